@@ rtl/had_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// had_pkg
// Shared types, constants and the arctangent table for the heading block.
// ---------------------------------------------------------------------------
package had_pkg;

	localparam int ANGLE_GUARD = 40;
	localparam int NORM_MSB    = 45;
	localparam int DP_W        = 50;
	localparam int Z_W         = 49;
	localparam int ROM_SIZE    = 32;
	localparam int ROM_IDX_W   = 5;
	localparam int NORM_STEPS  = 6;
	localparam int NORM_STEP_W = 3;
	localparam int SHAMT_W     = 7;
	localparam int HEADING_W   = 16;

	localparam logic [1:0] SPEC_NONE   = 2'd0;
	localparam logic [1:0] SPEC_ZERO   = 2'd1;
	localparam logic [1:0] SPEC_NINETY = 2'd2;

	localparam logic [Z_W-1:0] NINETY_DEG = Z_W'(90)  << ANGLE_GUARD;
	localparam logic [Z_W-1:0] HALF_TURN  = Z_W'(180) << ANGLE_GUARD;
	localparam logic [Z_W-1:0] FULL_TURN  = Z_W'(360) << ANGLE_GUARD;

	typedef logic signed [DP_W-1:0]          dp_t;
	typedef logic signed [Z_W-1:0]           ang_t;
	typedef logic [ROM_SIZE-1:0][Z_W-1:0]    rom_t;

	typedef struct packed {
		logic                 load;
		logic                 norm;
		logic                 rot;
		logic [ROM_IDX_W-1:0] idx;
	} had_cmd_t;

	localparam logic [63:0] Q60_ONE = 64'd1 << 60;

	// quotient by shift and subtract, table construction only
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], num[b]};
			q = q << 1;
			if (r >= {1'b0, den}) begin
				r = r - {1'b0, den};
				q = q | 64'd1;
			end
		end
		return q;
	endfunction

	// atan(2^-sh) in radians, Q60, alternating series
	function automatic logic [63:0] atan_pow2_q60(input int sh);
		logic [63:0] t;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] k;
		logic        add;
		t   = Q60_ONE >> sh;
		pos = '0;
		neg = '0;
		k   = 64'd1;
		add = 1'b1;
		while (t != 0) begin
			if (add) begin
				pos = pos + udiv64(t, k);
			end else begin
				neg = neg + udiv64(t, k);
			end
			add = !add;
			k   = k + 64'd2;
			t   = t >> (2 * sh);
		end
		return pos - neg;
	endfunction

	// pi/4 in Q60 from 4*atan(1/5) - atan(1/239)
	function automatic logic [63:0] quarter_pi_q60();
		logic [63:0] t;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] k;
		logic [63:0] a5;
		logic [63:0] a239;
		logic        add;
		t   = Q60_ONE / 5;
		pos = '0;
		neg = '0;
		k   = 64'd1;
		add = 1'b1;
		while (t != 0) begin
			if (add) begin
				pos = pos + udiv64(t, k);
			end else begin
				neg = neg + udiv64(t, k);
			end
			add = !add;
			k   = k + 64'd2;
			t   = t / 25;
		end
		a5  = pos - neg;
		t   = Q60_ONE / 239;
		pos = '0;
		neg = '0;
		k   = 64'd1;
		add = 1'b1;
		while (t != 0) begin
			if (add) begin
				pos = pos + udiv64(t, k);
			end else begin
				neg = neg + udiv64(t, k);
			end
			add = !add;
			k   = k + 64'd2;
			t   = t / 57121;
		end
		a239 = pos - neg;
		return 64'd4 * a5 - a239;
	endfunction

	// atan(2^-i) in degrees, ANGLE_GUARD fraction bits, truncated
	function automatic rom_t build_rom();
		rom_t        rom;
		logic [63:0] qp;
		logic [63:0] r;
		logic [63:0] q;
		qp     = quarter_pi_q60();
		rom[0] = Z_W'(45) << ANGLE_GUARD;
		for (int i = 1; i < ROM_SIZE; i++) begin
			r = atan_pow2_q60(i);
			q = '0;
			for (int b = 0; b < ANGLE_GUARD; b++) begin
				r = r << 1;
				q = q << 1;
				if (r >= qp) begin
					r = r - qp;
					q = q | 64'd1;
				end
			end
			q      = q * 64'd45;
			rom[i] = q[Z_W-1:0];
		end
		return rom;
	endfunction

	localparam rom_t ATAN_ROM = build_rom();

endpackage

@@ rtl/had_cordic_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// had_cordic_unit
// Shared x/y/z datapath: operand load, normalizing shift steps, and one
// CORDIC vectoring step per cycle against the arctangent table.
// ---------------------------------------------------------------------------
module had_cordic_unit import had_pkg::*; #(
	parameter int MAG_W = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  had_cmd_t         cmd,
	input  logic [MAG_W-1:0] load_x,
	input  logic [MAG_W-1:0] load_y,
	output ang_t             z
);

	dp_t                x_q;
	dp_t                y_q;
	ang_t               z_q;
	logic [SHAMT_W-1:0] shamt;
	logic [SHAMT_W-1:0] thr;
	logic               do_shift;
	dp_t                xs;
	dp_t                ys;
	ang_t               rom_val;

	always_comb begin
		shamt    = SHAMT_W'(32) >> cmd.idx[NORM_STEP_W-1:0];
		thr      = SHAMT_W'(NORM_MSB + 1) - shamt;
		do_shift = ((x_q | y_q) >> thr) == '0;
		xs       = x_q >>> cmd.idx;
		ys       = y_q >>> cmd.idx;
		rom_val  = $signed(ATAN_ROM[cmd.idx]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
		end else if (cmd.load) begin
			x_q <= dp_t'({{(DP_W - MAG_W){1'b0}}, load_x});
			y_q <= dp_t'({{(DP_W - MAG_W){1'b0}}, load_y});
			z_q <= '0;
		end else if (cmd.norm) begin
			if (do_shift) begin
				x_q <= x_q << shamt;
				y_q <= y_q << shamt;
			end
		end else if (cmd.rot) begin
			if (!y_q[DP_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + rom_val;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - rom_val;
			end
		end
	end

	assign z = z_q;

endmodule

@@ rtl/had_post.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// had_post
// Clamps the folded angle, places it in its quadrant, then rounds to the
// output fraction and wraps a full turn to zero.
// ---------------------------------------------------------------------------
module had_post import had_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 capture,
	input  ang_t                 z,
	input  logic [1:0]           spec,
	input  logic                 dx_neg,
	input  logic                 dy_neg,
	output logic [HEADING_W-1:0] heading
);

	localparam int RND_SH = ANGLE_GUARD - ANGLE_FRAC_BITS;
	localparam logic [DP_W-1:0] HALF_LSB = DP_W'(1) << (RND_SH - 1);
	localparam logic [DP_W-1:0] TURN = DP_W'(360) << ANGLE_FRAC_BITS;

	logic [Z_W-1:0]  zc;
	logic [Z_W-1:0]  full;
	logic [Z_W-1:0]  full_q;
	logic [DP_W-1:0] res;
	logic [DP_W-1:0] res_w;

	always_comb begin
		case (spec)
			SPEC_ZERO:   zc = '0;
			SPEC_NINETY: zc = NINETY_DEG;
			default: begin
				if (z[Z_W-1]) begin
					zc = '0;
				end else if (z > $signed(NINETY_DEG)) begin
					zc = NINETY_DEG;
				end else begin
					zc = z;
				end
			end
		endcase
		if (!dy_neg) begin
			full = dx_neg ? HALF_TURN - zc : zc;
		end else begin
			full = dx_neg ? HALF_TURN + zc : FULL_TURN - zc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
		end else if (capture) begin
			full_q <= full;
		end
	end

	always_comb begin
		res     = (DP_W'(full_q) + HALF_LSB) >> RND_SH;
		res_w   = (res >= TURN) ? res - TURN : res;
		heading = res_w[HEADING_W-1:0];
	end

endmodule

@@ rtl/heading_angle_degrees.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// heading_angle_degrees
// Heading of the vector between two points, degrees CCW from +x.
// ---------------------------------------------------------------------------
// Takes two points and returns the direction from the first to the second
// as an unsigned angle in [0,360) degrees with ANGLE_FRAC_BITS fraction bits;
// coincident points give 0. The difference vector is folded into the first
// quadrant, normalized by six binary shift steps, and measured by CORDIC
// vectoring, one iteration per cycle on a single shared shift/add unit. A
// vector that lies on an axis skips the shift steps and the iterations. The
// input is ready again the cycle after the result is written, and it is not
// ready while an item is in work; the result sits in an output register, so
// the next beat can be accepted while it waits.
// ---------------------------------------------------------------------------
module heading_angle_degrees import had_pkg::*; #(
	parameter int COORD_WIDTH     = 16,
	parameter int ANGLE_FRAC_BITS = 7,
	parameter int ITERATIONS      = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic signed [COORD_WIDTH-1:0] first_x,
	input  logic signed [COORD_WIDTH-1:0] first_y,
	input  logic signed [COORD_WIDTH-1:0] second_x,
	input  logic signed [COORD_WIDTH-1:0] second_y,
	output logic                          heading_valid,
	input  logic                          heading_ready,
	output logic [HEADING_W-1:0]          heading
);

	localparam int DIFF_W = COORD_WIDTH + 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_NORM  = 3'd1;
	localparam logic [2:0] ST_ROT   = 3'd2;
	localparam logic [2:0] ST_POST1 = 3'd3;
	localparam logic [2:0] ST_POST2 = 3'd4;

	localparam logic [ROM_IDX_W-1:0] NORM_LAST = ROM_IDX_W'(NORM_STEPS - 1);
	localparam logic [ROM_IDX_W-1:0] ROT_LAST  = ROM_IDX_W'(ITERATIONS - 1);

	logic [2:0]              state_q;
	logic [ROM_IDX_W-1:0]    step_q;
	logic [1:0]              spec_q;
	logic                    dx_neg_q;
	logic                    dy_neg_q;
	logic                    heading_valid_q;
	logic [HEADING_W-1:0]    heading_q;

	logic signed [DIFF_W-1:0] dx;
	logic signed [DIFF_W-1:0] dy;
	logic [DIFF_W-1:0]        ax;
	logic [DIFF_W-1:0]        ay;
	logic [1:0]               spec;
	logic                     accept;
	logic                     out_write;
	had_cmd_t                 cmd;
	ang_t                     z;
	logic [HEADING_W-1:0]     heading_new;

	always_comb begin
		dx     = DIFF_W'(second_x) - DIFF_W'(first_x);
		dy     = DIFF_W'(second_y) - DIFF_W'(first_y);
		ax     = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
		ay     = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
		if (ay == '0) begin
			spec = SPEC_ZERO;
		end else if (ax == '0) begin
			spec = SPEC_NINETY;
		end else begin
			spec = SPEC_NONE;
		end
		accept    = item_valid && item_ready;
		out_write = (state_q == ST_POST2) && (!heading_valid_q || heading_ready);
		cmd.load  = accept;
		cmd.norm  = (state_q == ST_NORM);
		cmd.rot   = (state_q == ST_ROT);
		cmd.idx   = step_q;
	end

	assign item_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			spec_q   <= SPEC_NONE;
			dx_neg_q <= 1'b0;
			dy_neg_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						spec_q   <= spec;
						dx_neg_q <= dx[DIFF_W-1];
						dy_neg_q <= dy[DIFF_W-1];
						step_q   <= '0;
						state_q  <= (spec == SPEC_NONE) ? ST_NORM : ST_POST1;
					end
				end
				ST_NORM: begin
					if (step_q == NORM_LAST) begin
						step_q  <= '0;
						state_q <= ST_ROT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_ROT: begin
					if (step_q == ROT_LAST) begin
						step_q  <= '0;
						state_q <= ST_POST1;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_POST1: begin
					state_q <= ST_POST2;
				end
				ST_POST2: begin
					if (out_write) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_valid_q <= 1'b0;
			heading_q       <= '0;
		end else if (out_write) begin
			heading_valid_q <= 1'b1;
			heading_q       <= heading_new;
		end else if (heading_ready) begin
			heading_valid_q <= 1'b0;
		end
	end

	had_cordic_unit #(
		.MAG_W(DIFF_W)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.load_x(ax),
		.load_y(ay),
		.z     (z)
	);

	had_post #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_post (
		.clk    (clk),
		.arst_n (arst_n),
		.capture(state_q == ST_POST1),
		.z      (z),
		.spec   (spec_q),
		.dx_neg (dx_neg_q),
		.dy_neg (dy_neg_q),
		.heading(heading_new)
	);

	assign heading_valid = heading_valid_q;
	assign heading       = heading_q;

endmodule
